// File: design/mld_pkg.sv
// Shared widths, register indexes and result codes for the marker/length deframer.
package mld_pkg;

    // Field and register widths.
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 32;
    localparam int LEN_W       = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = WORD_W;

    // Marker and length fields are four bytes each.
    localparam int MARK_BYTES  = 4;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_START_WORD  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_END_WORD    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD = 2'd2;

    // Reset value of the largest accepted payload length.
    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 16'hFFFF;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Frame status codes.
    localparam logic [STATUS_W-1:0] STATUS_GOOD     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_END  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LONG = 2'd2;

endpackage

// File: design/mld_byte_if.sv
// Valid/ready channel that carries one received byte per transfer.
interface mld_byte_if;

    logic                       valid;
    logic                       ready;
    logic [mld_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);

endinterface

// File: design/mld_result_if.sv
// Valid/ready channel that carries one payload byte or frame status per transfer.
interface mld_result_if;

    logic                         valid;
    logic                         ready;
    logic                         item_kind;
    logic [mld_pkg::BYTE_W-1:0]   payload_byte;
    logic                         is_first;
    logic                         is_last;
    logic [mld_pkg::STATUS_W-1:0] frame_status;

    modport source (output valid, output item_kind, output payload_byte,
                    output is_first, output is_last, output frame_status,
                    input ready);
    modport sink   (input valid, input item_kind, input payload_byte,
                    input is_first, input is_last, input frame_status,
                    output ready);

endinterface

// File: design/marker_length_deframer.sv
// Marker and length-prefix deframer: splits a byte stream into payload bytes and frame status.
//
// The rx channel takes one stream byte per transfer. The tx channel gives a payload byte
// (with first and last flags) or a frame status: good, bad end marker, or too long.
// Hunt and start marker bytes give no tx transfer; only a last length or end marker byte can.
// The configuration port writes the start marker, end marker and maximum payload length;
// write it only while no byte is in flight.
//
// Each byte is captured in an input register, decoded by one level of compare and
// update logic, and its result lands in the output register. A byte that produces a
// result passes through the input register and then the output register before it
// appears on tx, and a tx stall can hold it in either. One byte is taken every cycle
// unless a byte with a result waits on a stalled tx; the decode step adds no limit.
//
// After reset the block hunts for the start marker with an empty window, the maximum
// payload is 65535 and both markers are zero. When tx stalls, the output register holds
// its result, the input register holds the next byte, and rx ready drops once a byte
// that needs an output slot is waiting; bytes that produce no result still move on.
module marker_length_deframer
(
    input  logic                              clk,
    input  logic                              rst_n,
    mld_byte_if.sink                          rx,
    mld_result_if.source                      tx,
    input  logic                              cfg_we,
    input  logic [mld_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mld_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int BW = mld_pkg::BYTE_W;
    localparam int WW = mld_pkg::WORD_W;
    localparam int LW = mld_pkg::LEN_W;
    localparam logic [2:0] FILL_FULL = 3'(mld_pkg::MARK_BYTES);
    localparam logic [1:0] SUB_LAST  = 2'(mld_pkg::MARK_BYTES - 1);

    typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_PAYLOAD, PH_END} phase_t;

    // Configuration registers.
    logic [WW-1:0] start_word_reg;
    logic [WW-1:0] end_word_reg;
    logic [LW-1:0] max_payload_reg;

    // Input register.
    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;

    // Frame state.
    phase_t        phase_reg, phase_next;
    logic [WW-1:0] window_reg, window_next;
    logic [1:0]    sub_reg, sub_next;
    logic [LW-1:0] length_reg, length_next;
    logic [LW-1:0] count_reg, count_next;
    logic [2:0]    fill_reg, fill_next;

    // Output register.
    logic                         out_valid_reg;
    logic                         out_kind_reg;
    logic [BW-1:0]                out_byte_reg;
    logic                         out_first_reg;
    logic                         out_last_reg;
    logic [mld_pkg::STATUS_W-1:0] out_status_reg;

    // Decoded result of the byte in the input register.
    logic                         has_result;
    logic                         res_kind;
    logic [BW-1:0]                res_byte;
    logic                         res_first;
    logic                         res_last;
    logic [mld_pkg::STATUS_W-1:0] res_status;

    logic          out_free;
    logic          consume;
    logic [WW-1:0] shifted;
    logic [2:0]    fill_inc;
    logic          too_long;
    logic          last_byte;

    // Handshake between the two registers.
    assign out_free = !out_valid_reg || tx.ready;
    assign consume  = in_valid_reg && (!has_result || out_free);
    assign rx.ready = !in_valid_reg || consume;

    assign shifted   = {window_reg[WW-BW-1:0], in_byte_reg};
    assign fill_inc  = (fill_reg < FILL_FULL) ? fill_reg + 3'd1 : fill_reg;
    assign too_long  = (shifted[WW-1:LW] != '0) || (shifted[LW-1:0] > max_payload_reg);
    assign last_byte = ({1'b0, count_reg} + {{LW{1'b0}}, 1'b1}) >= {1'b0, length_reg};

    // Per-byte decode and state update.
    always_comb
    begin
        phase_next  = phase_reg;
        window_next = window_reg;
        sub_next    = sub_reg;
        length_next = length_reg;
        count_next  = count_reg;
        fill_next   = fill_reg;
        has_result  = 1'b0;
        res_kind    = mld_pkg::KIND_PAYLOAD;
        res_byte    = '0;
        res_first   = 1'b0;
        res_last    = 1'b0;
        res_status  = mld_pkg::STATUS_GOOD;

        case (phase_reg)
            PH_HUNT:
            begin
                window_next = shifted;
                fill_next   = fill_inc;
                if (fill_inc == FILL_FULL && shifted == start_word_reg)
                begin
                    phase_next  = PH_LENGTH;
                    window_next = '0;
                    fill_next   = '0;
                    sub_next    = '0;
                end
            end
            PH_LENGTH:
            begin
                window_next = shifted;
                if (sub_reg != SUB_LAST)
                begin
                    sub_next = sub_reg + 2'd1;
                end
                else if (too_long)
                begin
                    has_result  = 1'b1;
                    res_kind    = mld_pkg::KIND_STATUS;
                    res_status  = mld_pkg::STATUS_TOO_LONG;
                    phase_next  = PH_HUNT;
                    window_next = '0;
                    fill_next   = '0;
                    sub_next    = '0;
                end
                else
                begin
                    length_next = shifted[LW-1:0];
                    count_next  = '0;
                    window_next = '0;
                    sub_next    = '0;
                    phase_next  = (shifted[LW-1:0] == '0) ? PH_END : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                has_result = 1'b1;
                res_kind   = mld_pkg::KIND_PAYLOAD;
                res_byte   = in_byte_reg;
                res_first  = (count_reg == '0);
                res_last   = last_byte;
                count_next = count_reg + 16'd1;
                if (last_byte)
                begin
                    phase_next  = PH_END;
                    window_next = '0;
                    sub_next    = '0;
                end
            end
            PH_END:
            begin
                window_next = shifted;
                if (sub_reg != SUB_LAST)
                begin
                    sub_next = sub_reg + 2'd1;
                end
                else
                begin
                    has_result  = 1'b1;
                    res_kind    = mld_pkg::KIND_STATUS;
                    res_status  = (shifted == end_word_reg) ? mld_pkg::STATUS_GOOD
                                                            : mld_pkg::STATUS_BAD_END;
                    phase_next  = PH_HUNT;
                    window_next = '0;
                    fill_next   = '0;
                    sub_next    = '0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_word_reg  <= '0;
            end_word_reg    <= '0;
            max_payload_reg <= mld_pkg::MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mld_pkg::CFG_START_WORD:  start_word_reg  <= cfg_data;
                mld_pkg::CFG_END_WORD:    end_word_reg    <= cfg_data;
                mld_pkg::CFG_MAX_PAYLOAD: max_payload_reg <= cfg_data[LW-1:0];
                default:                  ;
            endcase
        end
    end

    // Input register and frame state; state advances when the held byte is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= PH_HUNT;
            window_reg   <= '0;
            sub_reg      <= '0;
            length_reg   <= '0;
            count_reg    <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (rx.ready)
            begin
                in_valid_reg <= rx.valid;
            end
            if (consume)
            begin
                phase_reg  <= phase_next;
                window_reg <= window_next;
                sub_reg    <= sub_next;
                length_reg <= length_next;
                count_reg  <= count_next;
                fill_reg   <= fill_next;
            end
        end
    end

    // Byte capture needs no reset.
    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= consume && has_result;
        end
    end

    // Output payload, loaded when a result is produced into a free slot.
    always_ff @(posedge clk)
    begin
        if (out_free && consume && has_result)
        begin
            out_kind_reg   <= res_kind;
            out_byte_reg   <= res_byte;
            out_first_reg  <= res_first;
            out_last_reg   <= res_last;
            out_status_reg <= res_status;
        end
    end

    assign tx.valid        = out_valid_reg;
    assign tx.item_kind    = out_kind_reg;
    assign tx.payload_byte = out_byte_reg;
    assign tx.is_first     = out_first_reg;
    assign tx.is_last      = out_last_reg;
    assign tx.frame_status = out_status_reg;

endmodule
